/* rtl/fpa_pkg.sv */
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

	localparam int OPND_BITS     = 32;
	localparam int FUNC_BITS     = 4;
	localparam int DEF_FRAC_BITS = 8;
	localparam int DEF_WORD_BITS = 32;

	typedef enum logic [FUNC_BITS-1:0] {
		FN_ADD    = 4'd0,
		FN_SUB    = 4'd1,
		FN_MUL    = 4'd2,
		FN_DIV    = 4'd3,
		FN_GT     = 4'd4,
		FN_LT     = 4'd5,
		FN_GE     = 4'd6,
		FN_LE     = 4'd7,
		FN_EQ     = 4'd8,
		FN_NE     = 4'd9,
		FN_MIN    = 4'd10,
		FN_MAX    = 4'd11,
		FN_INC    = 4'd12,
		FN_DEC    = 4'd13,
		FN_TO_INT = 4'd14
	} func_t;

endpackage

/* rtl/fpa_if.sv */
// Item channels of the fixed-point ALU: request and response.
interface fpa_req_if import fpa_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [FUNC_BITS-1:0]        func;
	logic signed [OPND_BITS-1:0] operand_a;
	logic signed [OPND_BITS-1:0] operand_b;

	modport source (output valid, func, operand_a, operand_b, input ready);
	modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [OPND_BITS-1:0] result_word;
	logic                        compare_true;
	logic                        divide_by_zero;
	logic                        overflowed;

	modport source (output valid, result_word, compare_true, divide_by_zero, overflowed,
		input ready);
	modport sink   (input valid, result_word, compare_true, divide_by_zero, overflowed,
		output ready);
endinterface

/* rtl/fixed_point_alu.sv */
// Fixed-point ALU top level: decode, multiplier, pipelined divider and saturation.
//
// Usage
//   req carries one item per valid/ready handshake: func, operand_a, operand_b
//   (raw two's-complement words with FRAC_BITS fraction bits). rsp returns
//   one item per request: result_word and the compare_true, divide_by_zero
//   and overflowed flags, in request order.
// Pipeline
//   Every operation takes the same path to rsp: an input register, a decode
//   and multiply stage, 33 + FRAC_BITS restoring divide stages (one quotient
//   bit each) and a round/saturate stage. One item is accepted every cycle
//   while rsp is not stalled; the divider chain sets the depth.
// Reset
//   arst_n clears all valid bits at once; the pipeline is empty and req.ready
//   is high straight after reset.
// Stalls
//   While rsp.valid is high and rsp.ready low the whole pipeline holds,
//   bubbles included, and req.ready drops. Nothing is lost or repeated.
module fixed_point_alu import fpa_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	fpa_req_if.sink          req,
	fpa_rsp_if.source        rsp
);

	// operand width, numerator (2*|a| << F) width, divider depth
	localparam int OW = (WORD_BITS < OPND_BITS) ? WORD_BITS : OPND_BITS;
	localparam int NB = OPND_BITS + FRAC_BITS + 1;
	localparam int QB = NB;
	localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (WORD_BITS - 1)) - 66'sd1;
	localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;
	localparam logic [63:0]        HALF   = 64'd1 << (FRAC_BITS - 1);

	typedef struct packed {
		logic [FUNC_BITS-1:0] func;
		logic                 neg;
		logic [31:0]          simple;
		logic                 cmp;
		logic                 ovf;
		logic                 dz;
		logic [63:0]          prod;
		logic [NB-1:0]        num;
		logic [31:0]          rem;
		logic [31:0]          den;
	} stage_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] word;
	} sat_t;

	function automatic sat_t saturate(input logic signed [65:0] v);
		sat_t s;
		s.ovf = 1'b0;
		s.word = v[31:0];
		if (v > SAT_HI) begin
			s.ovf = 1'b1;
			s.word = SAT_HI[31:0];
		end else if (v < SAT_LO) begin
			s.ovf = 1'b1;
			s.word = SAT_LO[31:0];
		end
		return s;
	endfunction

	// global advance: move whenever the output slot is free or being taken
	logic en;
	logic vld_sf;
	assign en = !vld_sf || rsp.ready;
	assign req.ready = en;

	// stage 1: input register, operands cut to OW bits and sign-extended to 33 bits
	logic                  vld_s1;
	logic [FUNC_BITS-1:0]  func_s1;
	logic signed [32:0]    a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= req.func;
			a_s1    <= 33'(signed'(req.operand_a[OW-1:0]));
			b_s1    <= 33'(signed'(req.operand_b[OW-1:0]));
		end
	end

	// stage 2: simple ops, magnitudes, multiply, divider set-up
	logic               vld_s2;
	stage_t             st_s2;
	stage_t             st_n2;
	logic signed [65:0] a_w, b_w;
	logic signed [32:0] a_m, b_m;
	sat_t               sr;

	always_comb begin
		a_w = 66'(a_s1);
		b_w = 66'(b_s1);
		a_m = a_s1[32] ? -a_s1 : a_s1;
		b_m = b_s1[32] ? -b_s1 : b_s1;
		st_n2 = '0;
		st_n2.func = func_s1;
		st_n2.neg  = a_s1[32] ^ b_s1[32];
		st_n2.prod = 64'(a_m[31:0]) * 64'(b_m[31:0]);
		st_n2.num  = NB'(a_m[31:0]) << (FRAC_BITS + 1);
		st_n2.den  = b_m[31:0];
		st_n2.dz   = (func_s1 == FN_DIV) && (b_s1 == '0);
		sr = '0;
		unique case (func_s1)
			FN_ADD:    sr = saturate(a_w + b_w);
			FN_SUB:    sr = saturate(a_w - b_w);
			FN_INC:    sr = saturate(a_w + 66'sd1);
			FN_DEC:    sr = saturate(a_w - 66'sd1);
			FN_MIN:    sr.word = (a_s1 < b_s1) ? a_s1[31:0] : b_s1[31:0];
			FN_MAX:    sr.word = (a_s1 > b_s1) ? a_s1[31:0] : b_s1[31:0];
			FN_TO_INT: sr.word = 32'(a_s1 >>> FRAC_BITS);
			FN_GT:     st_n2.cmp = a_s1 > b_s1;
			FN_LT:     st_n2.cmp = a_s1 < b_s1;
			FN_GE:     st_n2.cmp = a_s1 >= b_s1;
			FN_LE:     st_n2.cmp = a_s1 <= b_s1;
			FN_EQ:     st_n2.cmp = a_s1 == b_s1;
			FN_NE:     st_n2.cmp = a_s1 != b_s1;
			default:   sr = '0;
		endcase
		st_n2.simple = sr.word;
		st_n2.ovf    = sr.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s2 <= st_n2;
		end
	end

	// divider chain: one restoring step per stage; the first also rounds the product
	stage_t dv_s   [QB];
	logic   dv_vld [QB];
	stage_t dv_src [QB];
	logic   dv_vsrc[QB];

	assign dv_src[0]  = st_s2;
	assign dv_vsrc[0] = vld_s2;

	for (genvar k = 0; k < QB; k++) begin : g_div
		stage_t      nx;
		logic [32:0] rsh;

		if (k > 0) begin : g_link
			assign dv_src[k]  = dv_s[k-1];
			assign dv_vsrc[k] = dv_vld[k-1];
		end

		always_comb begin
			nx  = dv_src[k];
			rsh = {dv_src[k].rem, dv_src[k].num[NB-1]};
			if (rsh >= {1'b0, dv_src[k].den}) begin
				nx.rem = 32'(rsh - {1'b0, dv_src[k].den});
				nx.num = {dv_src[k].num[NB-2:0], 1'b1};
			end else begin
				nx.rem = rsh[31:0];
				nx.num = {dv_src[k].num[NB-2:0], 1'b0};
			end
			if (k == 0) begin
				nx.prod = (dv_src[k].prod + HALF) >> FRAC_BITS;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k] <= 1'b0;
			end else if (en) begin
				dv_vld[k] <= dv_vsrc[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= nx;
			end
		end
	end

	// final stage: round quotient, apply sign, saturate, select
	stage_t             fin;
	logic [NB:0]        q_rnd;
	logic signed [65:0] q_sv, m_sv;
	sat_t               qs, ms;
	logic [31:0]        res_n;
	logic               ovf_n;
	logic [31:0]        res_sf;
	logic               cmp_sf, dz_sf, ovf_sf;

	always_comb begin
		fin   = dv_s[QB-1];
		q_rnd = ({1'b0, fin.num} + (NB+1)'(1)) >> 1;
		q_sv  = fin.neg ? -$signed(66'(q_rnd)) : $signed(66'(q_rnd));
		m_sv  = fin.neg ? -$signed({2'b00, fin.prod}) : $signed({2'b00, fin.prod});
		qs    = saturate(q_sv);
		ms    = saturate(m_sv);
		priority if (fin.func == FN_MUL) begin
			res_n = ms.word;
			ovf_n = ms.ovf;
		end else if (fin.func == FN_DIV) begin
			res_n = fin.dz ? '0 : qs.word;
			ovf_n = !fin.dz && qs.ovf;
		end else begin
			res_n = fin.simple;
			ovf_n = fin.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sf <= dv_vld[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sf <= res_n;
			ovf_sf <= ovf_n;
			cmp_sf <= fin.cmp;
			dz_sf  <= fin.dz;
		end
	end

	assign rsp.valid          = vld_sf;
	assign rsp.result_word    = res_sf;
	assign rsp.compare_true   = cmp_sf;
	assign rsp.divide_by_zero = dz_sf;
	assign rsp.overflowed     = ovf_sf;

	// divide by zero gives a clean zero
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.divide_by_zero |-> rsp.result_word == '0 && !rsp.overflowed)
		else $error("divide by zero with non-zero result or overflow");

	// comparisons give only the compare flag
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.compare_true |->
			rsp.result_word == '0 && !rsp.overflowed && !rsp.divide_by_zero)
		else $error("comparison item carries other results");

	// saturation lands on a word limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.overflowed |->
			rsp.result_word == SAT_HI[31:0] || rsp.result_word == SAT_LO[31:0])
		else $error("overflow flagged off the saturation limits");

endmodule
